// ----- rtl/bba_pkg.sv -----
// Shared types and constants for the block bitmap allocator.
// No dependencies; used by every module of the block.
`default_nettype none
package bba_pkg;

    localparam int BBA_MAX_BLOCKS = 4096;
    localparam int BBA_MAX_GROUPS = 8;

    localparam int WORD_BITS = 32;
    localparam int OFF_W     = 5;
    localparam int CNT_W     = 13;
    localparam int BLK_W     = 12;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;

    localparam logic [CNT_W-1:0] CNT_MAX   = 13'h1FFF;
    localparam logic [CNT_W-1:0] TOTAL_RST = 13'd4096;
    localparam logic [CNT_W-1:0] BPG_RST   = 13'd512;

    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_CLEAR   = 3'd0;
    localparam op_t OP_TEST    = 3'd1;
    localparam op_t OP_ALLOC   = 3'd2;
    localparam op_t OP_RELEASE = 3'd3;
    localparam op_t OP_FIND    = 3'd4;

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_USED = 2'd1;
    localparam status_t ST_FREE = 2'd2;

    localparam logic CFG_TOTAL = 1'b0;
    localparam logic CFG_BPG   = 1'b1;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DIV,
        S_GRD,
        S_UPD,
        S_SCAN_RD,
        S_SCAN_CHK
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_run;
        logic sweep;
        logic sweep_start;
        logic update;
        logic scan_rd;
        logic scan_chk;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic sweep_last;
        logic op_clear;
        logic op_find;
        logic scan_end;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/bba_div.sv -----
// Restoring divider, one quotient bit per cycle: block number by group size.
// Depends on bba_pkg.
`default_nettype none
module bba_div
    import bba_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic [BLK_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [BLK_W-1:0]      quotient
);

    localparam int CW = $clog2(BLK_W);

    logic [BLK_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;

    // one shift-subtract step
    always_comb
    begin
        trial    = {rem_reg, q_reg[BLK_W-1]};
        diff     = trial - {1'b0, divisor};
        ge       = trial >= {1'b0, divisor};
        done     = run_reg && (cnt_reg == CW'(BLK_W - 1));
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (load)
        begin
            q_next   = dividend;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            q_next   = {q_reg[BLK_W-2:0], ge};
            rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            run_next = !done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign quotient = q_reg;

endmodule
`default_nettype wire

// ----- rtl/bba_ctrl.sv -----
// Operation sequencer: divide, sweep, group read, update and scan steps.
// Depends on bba_pkg.
`default_nettype none
module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd,
    output logic           busy
);

    state_t state_reg, state_next;
    logic   rst_sweep_reg, rst_sweep_next;

    // next state
    always_comb
    begin
        state_next     = state_reg;
        rst_sweep_next = rst_sweep_reg;
        unique case (state_reg)
            S_SWEEP:
            begin
                if (stat.sweep_last)
                    state_next = rst_sweep_reg ? S_IDLE : S_GRD;
            end
            S_IDLE:
            begin
                rst_sweep_next = 1'b0;
                if (start)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = stat.op_clear ? S_SWEEP : S_GRD;
            end
            S_GRD:      state_next = S_UPD;
            S_UPD:      state_next = stat.op_find ? S_SCAN_RD : S_IDLE;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK: state_next = stat.scan_end ? S_IDLE : S_SCAN_RD;
            default:    state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd             = '0;
        cmd.accept      = (state_reg == S_IDLE) && start;
        cmd.div_run     = (state_reg == S_DIV);
        cmd.sweep_start = (state_reg == S_DIV) && stat.div_done && stat.op_clear;
        cmd.sweep       = (state_reg == S_SWEEP);
        cmd.update      = (state_reg == S_UPD);
        cmd.scan_rd     = (state_reg == S_SCAN_RD);
        cmd.scan_chk    = (state_reg == S_SCAN_CHK);
        cmd.finish      = ((state_reg == S_UPD) && !stat.op_find)
                       || ((state_reg == S_SCAN_CHK) && stat.scan_end);
        busy            = (state_reg != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            rst_sweep_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            rst_sweep_reg <= rst_sweep_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bba_datapath.sv -----
// Bitmap and group-counter memories, counters, config registers, scan logic.
// Depends on bba_pkg and bba_div.
`default_nettype none
module bba_datapath
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = BBA_MAX_BLOCKS,
    parameter int MAX_GROUPS = BBA_MAX_GROUPS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctrl_cmd_t        cmd,
    output dp_stat_t              stat,
    input  wire logic [OP_W-1:0]  operation,
    input  wire logic [BLK_W-1:0] block_id,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CNT_W-1:0] cfg_data,
    output logic                  done,
    output logic [STAT_W-1:0]     status,
    output logic                  was_used,
    output logic                  found,
    output logic [BLK_W-1:0]      found_block,
    output logic [CNT_W-1:0]      free_total,
    output logic [CNT_W-1:0]      free_in_group
);

    localparam int WORDS   = MAX_BLOCKS / WORD_BITS;
    localparam int AW      = $clog2(WORDS);
    localparam int GW      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int SWEEP_N = (WORDS > MAX_GROUPS) ? WORDS : MAX_GROUPS;
    localparam int SW      = $clog2(SWEEP_N);

    // lowest set bit
    function automatic logic [OFF_W-1:0] low_one(input logic [WORD_BITS-1:0] v);
        logic [OFF_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
                r = OFF_W'(i);
        end
        return r;
    endfunction

    // configuration
    logic [CNT_W-1:0] total_reg, bpg_reg;
    logic [CNT_W-1:0] t_eff, bpg_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RST;
            bpg_reg   <= BPG_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TOTAL: total_reg <= cfg_data;
                CFG_BPG:   bpg_reg   <= cfg_data;
                default:   total_reg <= total_reg;
            endcase
        end
    end

    assign t_eff   = (32'(total_reg) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : total_reg;
    assign bpg_eff = (bpg_reg == '0) ? CNT_W'(1) : bpg_reg;

    // item latch
    op_t              op_reg;
    logic [BLK_W-1:0] blk_reg;
    logic             in_range_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= operation;
            blk_reg      <= block_id;
            in_range_reg <= CNT_W'(block_id) < t_eff;
        end
    end

    // group number
    logic [BLK_W-1:0] quot;
    logic [31:0]      quot32;
    logic             grp_ok;
    logic [GW-1:0]    grp_idx;

    bba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.accept),
        .dividend (block_id),
        .divisor  (bpg_eff),
        .done     (stat.div_done),
        .quotient (quot)
    );

    assign quot32  = 32'(quot);
    assign grp_ok  = quot32 < MAX_GROUPS;
    assign grp_idx = quot32[GW-1:0];

    // clearing sweep
    logic [SW-1:0]    sw_idx_reg;
    logic [31:0]      sw_idx32;
    logic [31:0]      acc_reg;
    logic [31:0]      acc_diff;
    logic [CNT_W-1:0] sweep_n;

    assign sw_idx32        = 32'(sw_idx_reg);
    assign stat.sweep_last = cmd.sweep && (sw_idx32 == SWEEP_N - 1);
    assign acc_diff        = 32'(t_eff) - acc_reg;

    always_comb
    begin
        sweep_n = '0;
        if (acc_reg < 32'(t_eff))
            sweep_n = (acc_diff > 32'(bpg_eff)) ? bpg_eff : acc_diff[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_idx_reg <= '0;
            acc_reg    <= '0;
        end
        else if (cmd.sweep_start)
        begin
            sw_idx_reg <= '0;
            acc_reg    <= '0;
        end
        else if (cmd.sweep)
        begin
            sw_idx_reg <= sw_idx_reg + 1'b1;
            acc_reg    <= acc_reg + 32'(bpg_eff);
        end
    end

    // scan state
    logic [AW-1:0]        scan_w_reg;
    logic                 pass2_reg;
    logic [CNT_W-1:0]     lo_reg, hi_reg, start_reg;
    logic [31:0]          scan_w32, blk32;
    logic [31:0]          last_w32;
    logic [WORD_BITS-1:0] lo_mask, hi_mask, cand;
    logic                 hit, at_last;
    logic [31:0]          hit_id;
    logic [CNT_W-1:0]     scan_start;

    // bitmap memory
    logic [WORD_BITS-1:0] bmap_mem [WORDS];
    logic [WORD_BITS-1:0] bm_rdata_reg;
    logic [AW-1:0]        bm_raddr, bm_waddr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic                 bm_we;
    logic [WORD_BITS-1:0] word_reg;
    logic                 was_reg;

    assign blk32    = 32'(blk_reg);
    assign bm_raddr = (cmd.scan_rd) ? scan_w_reg : blk32[AW+OFF_W-1:OFF_W];

    always_ff @(posedge clk)
    begin
        if (bm_we)
            bmap_mem[bm_waddr] <= bm_wdata;
        bm_rdata_reg <= bmap_mem[bm_raddr];
    end

    // used bit of the addressed block, taken once its word is read
    always_ff @(posedge clk)
    begin
        if (cmd.div_run && stat.div_done)
        begin
            was_reg  <= in_range_reg ? bm_rdata_reg[blk_reg[OFF_W-1:0]] : 1'b1;
            word_reg <= bm_rdata_reg;
        end
    end

    // group counter memory
    logic [CNT_W-1:0] grp_mem [MAX_GROUPS];
    logic [CNT_W-1:0] grp_rdata_reg;
    logic [GW-1:0]    grp_waddr;
    logic [CNT_W-1:0] grp_wdata;
    logic             grp_we;

    always_ff @(posedge clk)
    begin
        if (grp_we)
            grp_mem[grp_waddr] <= grp_wdata;
        grp_rdata_reg <= grp_mem[grp_idx];
    end

    // update decision
    logic             do_alloc, do_release;
    logic [CNT_W-1:0] free_total_reg, total_new, grp_new;
    status_t          st_new;
    logic [WORD_BITS-1:0] bit_sel;

    assign bit_sel    = WORD_BITS'(1) << blk_reg[OFF_W-1:0];
    assign do_alloc   = (op_reg == OP_ALLOC) && !was_reg;
    assign do_release = (op_reg == OP_RELEASE) && was_reg && in_range_reg;

    always_comb
    begin
        total_new = free_total_reg;
        grp_new   = grp_rdata_reg;
        st_new    = ST_OK;
        if (do_alloc)
        begin
            total_new = (free_total_reg == '0) ? '0 : free_total_reg - 1'b1;
            grp_new   = (grp_rdata_reg == '0) ? '0 : grp_rdata_reg - 1'b1;
        end
        else if (do_release)
        begin
            total_new = (free_total_reg == CNT_MAX) ? CNT_MAX : free_total_reg + 1'b1;
            grp_new   = (grp_rdata_reg == CNT_MAX) ? CNT_MAX : grp_rdata_reg + 1'b1;
        end
        if ((op_reg == OP_ALLOC) && was_reg)
            st_new = ST_USED;
        else if ((op_reg == OP_RELEASE) && !do_release)
            st_new = ST_FREE;
    end

    // memory write ports
    always_comb
    begin
        bm_we     = 1'b0;
        bm_waddr  = blk32[AW+OFF_W-1:OFF_W];
        bm_wdata  = word_reg;
        grp_we    = 1'b0;
        grp_waddr = grp_idx;
        grp_wdata = grp_new;
        if (cmd.sweep)
        begin
            bm_we     = sw_idx32 < WORDS;
            bm_waddr  = sw_idx32[AW-1:0];
            bm_wdata  = '0;
            grp_we    = sw_idx32 < MAX_GROUPS;
            grp_waddr = sw_idx32[GW-1:0];
            grp_wdata = sweep_n;
        end
        else if (cmd.update)
        begin
            bm_we    = do_alloc || do_release;
            bm_wdata = do_alloc ? (word_reg | bit_sel) : (word_reg & ~bit_sel);
            grp_we   = (do_alloc || do_release) && grp_ok;
        end
    end

    // total free counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            free_total_reg <= '0;
        else if (stat.sweep_last)
            free_total_reg <= t_eff;
        else if (cmd.update)
            free_total_reg <= total_new;
    end

    // scan: masked free bits of the current word
    assign scan_w32   = 32'(scan_w_reg);
    assign last_w32   = (hi_reg == '0) ? 32'd0 : (32'(hi_reg) - 32'd1) >> OFF_W;
    assign lo_mask    = (scan_w32 == (32'(lo_reg) >> OFF_W))
                      ? ~((WORD_BITS'(1) << lo_reg[OFF_W-1:0]) - 1'b1) : '1;
    assign hi_mask    = (scan_w32 == (32'(hi_reg) >> OFF_W))
                      ? ((WORD_BITS'(1) << hi_reg[OFF_W-1:0]) - 1'b1) : '1;
    assign cand       = ~bm_rdata_reg & lo_mask & hi_mask;
    assign hit        = |cand;
    assign hit_id     = (scan_w32 << OFF_W) | 32'(low_one(cand));
    assign at_last    = scan_w32 == last_w32;
    assign scan_start = in_range_reg ? CNT_W'(blk_reg) : '0;
    assign stat.scan_end = hit || (at_last && (pass2_reg || start_reg == '0));

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            start_reg  <= scan_start;
            lo_reg     <= scan_start;
            hi_reg     <= t_eff;
            pass2_reg  <= 1'b0;
            scan_w_reg <= scan_start[AW+OFF_W-1:OFF_W];
        end
        else if (cmd.scan_chk && !stat.scan_end)
        begin
            if (at_last)
            begin
                // wrap to block zero for the second pass
                pass2_reg  <= 1'b1;
                lo_reg     <= '0;
                hi_reg     <= start_reg;
                scan_w_reg <= '0;
            end
            else
                scan_w_reg <= scan_w_reg + 1'b1;
        end
    end

    // result registers
    logic                 done_reg;
    status_t              status_reg;
    logic                 was_out_reg, found_reg;
    logic [BLK_W-1:0]     found_block_reg;
    logic [CNT_W-1:0]     fig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status_reg      <= st_new;
            was_out_reg     <= was_reg;
            found_reg       <= 1'b0;
            found_block_reg <= '0;
            fig_reg         <= grp_ok ? grp_new : '0;
        end
        else if (cmd.scan_chk && hit)
        begin
            found_reg       <= 1'b1;
            found_block_reg <= hit_id[BLK_W-1:0];
        end
    end

    assign stat.op_clear = (op_reg == OP_CLEAR);
    assign stat.op_find  = (op_reg == OP_FIND);

    assign done          = done_reg;
    assign status        = status_reg;
    assign was_used      = was_out_reg;
    assign found         = found_reg;
    assign found_block   = found_block_reg;
    assign free_total    = free_total_reg;
    assign free_in_group = fig_reg;

endmodule
`default_nettype wire

// ----- rtl/block_bitmap_allocator_unit.sv -----
// Top level of the block bitmap allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_datapath.
//
//  channel  | ports                                         | transfer when
//  ---------+-----------------------------------------------+-------------------
//  command  | start, busy, operation, block_id              | start && !busy
//  result   | done, status, was_used, found, found_block,   | done (one cycle)
//           | free_total, free_in_group                     |
//  config   | cfg_wr_en, cfg_index, cfg_data                | cfg_wr_en
//
// Test, allocate, release: after the transfer the 12-step group divider runs,
// then the group read and update states; done follows the update, and the next
// transfer can come while done is high. Find-free then reads and checks each
// 32-bit bitmap word scanned in turn (one memory read port). Clear sweeps both
// memories over max(MAX_BLOCKS/32, MAX_GROUPS) entries; after reset the same
// sweep runs with busy high. One item at a time; results cannot be held off.
`default_nettype none
module block_bitmap_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = BBA_MAX_BLOCKS,
    parameter int MAX_GROUPS = BBA_MAX_GROUPS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [OP_W-1:0]  operation,
    input  wire logic [BLK_W-1:0] block_id,
    output logic                  done,
    output logic [STAT_W-1:0]     status,
    output logic                  was_used,
    output logic                  found,
    output logic [BLK_W-1:0]      found_block,
    output logic [CNT_W-1:0]      free_total,
    output logic [CNT_W-1:0]      free_in_group,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CNT_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    bba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .block_id      (block_id),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .was_used      (was_used),
        .found         (found),
        .found_block   (found_block),
        .free_total    (free_total),
        .free_in_group (free_in_group)
    );

`ifndef SYNTHESIS
    // an accepted command keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in progress");

    // a found block never comes with a failure status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ST_OK))
        else $error("found flag with failure status");

    // free count never exceeds the managed block count
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(free_total) <= MAX_BLOCKS))
        else $error("free total above block count");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_block_bitmap_allocator_unit.sv -----
// Self-checking testbench for block_bitmap_allocator_unit: directed table, then random phases.
// Depends on bba_pkg and the allocator RTL; expected results come from an in-bench predictor.
`timescale 1ns / 100ps
module tb_block_bitmap_allocator_unit;
    import bba_pkg::*;

    localparam op_t OP_SPARE5 = 3'd5;
    localparam op_t OP_SPARE6 = 3'd6;
    localparam op_t OP_SPARE7 = 3'd7;

    typedef struct {
        status_t          status;
        logic             was_used;
        logic             found;
        logic [BLK_W-1:0] found_block;
        logic [CNT_W-1:0] free_total;
        logic [CNT_W-1:0] free_in_group;
    } alloc_res_t;

    typedef struct {
        op_t              op;
        logic [BLK_W-1:0] blk;
        bit               typed;
        alloc_res_t       res;
    } cmd_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [OP_W-1:0]  operation;
    logic [BLK_W-1:0] block_id;
    logic             done;
    logic [STAT_W-1:0] status;
    logic             was_used;
    logic             found;
    logic [BLK_W-1:0] found_block;
    logic [CNT_W-1:0] free_total;
    logic [CNT_W-1:0] free_in_group;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [CNT_W-1:0] cfg_data;

    block_bitmap_allocator_unit dut (.*);

    // shadow state of the allocator
    bit               shadow_used [BBA_MAX_BLOCKS];
    int unsigned      shadow_total_cfg;
    int unsigned      shadow_bpg_cfg;
    int unsigned      shadow_free_total;
    int unsigned      shadow_free_grp [BBA_MAX_GROUPS];

    alloc_res_t       pending_results[$];
    bit               cur_typed;
    alloc_res_t       cur_typed_res;
    int               mismatches;
    int               results_seen;
    int               finds_hit;
    int               finds_miss;
    int               fails_seen;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned eff_blocks();
        return (shadow_total_cfg > BBA_MAX_BLOCKS) ? BBA_MAX_BLOCKS : shadow_total_cfg;
    endfunction

    function automatic int unsigned eff_group_size();
        return (shadow_bpg_cfg == 0) ? 1 : shadow_bpg_cfg;
    endfunction

    function automatic void clear_bitmap();
        int unsigned t;
        int unsigned g_sz;
        longint unsigned first;
        longint unsigned n;
        t    = eff_blocks();
        g_sz = eff_group_size();
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        shadow_free_total = t;
        for (int g = 0; g < BBA_MAX_GROUPS; g++) begin
            first = longint'(g) * g_sz;
            n = 0;
            if (first < t) begin
                n = 64'(t) - first;
                if (n > g_sz) n = 64'(g_sz);
            end
            shadow_free_grp[g] = 32'((n > CNT_MAX) ? 64'(CNT_MAX) : n);
        end
    endfunction

    function automatic int unsigned cnt_dec(int unsigned v);
        return (v == 0) ? 0 : v - 1;
    endfunction

    function automatic int unsigned cnt_inc(int unsigned v);
        return (v >= CNT_MAX) ? 32'(CNT_MAX) : v + 1;
    endfunction

    // apply one command to the shadow state and return its result
    function automatic alloc_res_t apply_command(op_t op, logic [BLK_W-1:0] blk);
        alloc_res_t  r;
        int unsigned t;
        int unsigned grp;
        int unsigned scan_from;
        int unsigned id;
        bit          grp_kept;
        bit          in_range;
        bit          prior;
        t        = eff_blocks();
        grp      = 32'(blk) / eff_group_size();
        grp_kept = grp < BBA_MAX_GROUPS;
        in_range = 32'(blk) < t;
        prior    = in_range ? shadow_used[blk] : 1'b1;
        r.status = ST_OK;
        r.found  = 1'b0;
        r.found_block = '0;
        case (op)
            OP_CLEAR: clear_bitmap();
            OP_ALLOC: begin
                if (prior) r.status = ST_USED;
                else begin
                    shadow_used[blk] = 1'b1;
                    shadow_free_total = cnt_dec(shadow_free_total);
                    if (grp_kept) shadow_free_grp[grp] = cnt_dec(shadow_free_grp[grp]);
                end
            end
            OP_RELEASE: begin
                if (!prior || !in_range) r.status = ST_FREE;
                else begin
                    shadow_used[blk] = 1'b0;
                    shadow_free_total = cnt_inc(shadow_free_total);
                    if (grp_kept) shadow_free_grp[grp] = cnt_inc(shadow_free_grp[grp]);
                end
            end
            OP_FIND: begin
                scan_from = in_range ? 32'(blk) : 0;
                for (int unsigned i = 0; i < t; i++) begin
                    id = scan_from + i;
                    if (id >= t) id -= t;
                    if (!shadow_used[id]) begin
                        r.found = 1'b1;
                        r.found_block = BLK_W'(id);
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.was_used      = prior;
        r.free_total    = CNT_W'(shadow_free_total);
        r.free_in_group = grp_kept ? CNT_W'(shadow_free_grp[grp]) : '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // transfer tracking, shadow update and result checking at the rising edge
    always @(posedge clk) begin
        alloc_res_t p;
        alloc_res_t want;
        if (rst_n) begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_TOTAL) shadow_total_cfg = 32'(cfg_data);
                else                        shadow_bpg_cfg   = 32'(cfg_data);
            end
            if (start && !busy) begin
                p = apply_command(operation, block_id);
                pending_results.push_back(cur_typed ? cur_typed_res : p);
                if (operation == OP_FIND) begin
                    if (p.found) finds_hit++;
                    else         finds_miss++;
                end
                if (p.status != ST_OK) fails_seen++;
            end
            if (done) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t result with nothing outstanding", $realtime);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (status != want.status) report_mismatch("status", status, want.status);
                    if (was_used != want.was_used)
                        report_mismatch("was_used", was_used, want.was_used);
                    if (found != want.found) report_mismatch("found", found, want.found);
                    if (found_block != want.found_block)
                        report_mismatch("found_block", found_block, want.found_block);
                    if (free_total != want.free_total)
                        report_mismatch("free_total", free_total, want.free_total);
                    if (free_in_group != want.free_in_group)
                        report_mismatch("free_in_group", free_in_group, want.free_in_group);
                end
            end
        end
    end

    // present one command and hold it until the transfer
    task automatic issue(op_t op, logic [BLK_W-1:0] blk, bit typed, alloc_res_t res);
        @(negedge clk);
        start         = 1'b1;
        operation     = op;
        block_id      = blk;
        cur_typed     = typed;
        cur_typed_res = res;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    task automatic pause(int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // register write once all outstanding results are back
    task automatic write_reg(logic idx, int unsigned val);
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = CNT_W'(val);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic alloc_res_t mk(status_t st, int unsigned wu, int unsigned fd,
                                      int unsigned fb, int unsigned ft, int unsigned fg);
        alloc_res_t r;
        r.status = st; r.was_used = wu[0]; r.found = fd[0]; r.found_block = BLK_W'(fb);
        r.free_total = CNT_W'(ft); r.free_in_group = CNT_W'(fg);
        return r;
    endfunction

    function automatic op_t pick_op();
        int unsigned w;
        w = $urandom_range(0, 99);
        if (w < 38) return OP_ALLOC;
        if (w < 62) return OP_RELEASE;
        if (w < 82) return OP_FIND;
        if (w < 92) return OP_TEST;
        if (w < 95) return OP_CLEAR;
        if (w < 97) return OP_SPARE5;
        if (w < 99) return OP_SPARE6;
        return OP_SPARE7;
    endfunction

    initial begin
        cmd_row_t   rows[$];
        alloc_res_t none;
        int unsigned ph_total[8];
        int unsigned ph_bpg[8];
        int unsigned lim;
        int          wait_cycles;
        logic [BLK_W-1:0] blk;

        ph_total = '{4096, 1, 0, 8191, 100, 4096, 37, 3000};
        ph_bpg   = '{512, 8, 0, 4096, 8, 8191, 13, 400};
        rst_n = 1'b0; start = 1'b0; operation = OP_TEST; block_id = '0;
        cfg_wr_en = 1'b0; cfg_index = CFG_TOTAL; cfg_data = '0;
        cur_typed = 1'b0; cur_typed_res = '{default: '0}; none = '{default: '0};
        mismatches = 0; results_seen = 0; finds_hit = 0; finds_miss = 0; fails_seen = 0;
        shadow_total_cfg = 32'(TOTAL_RST);
        shadow_bpg_cfg   = 32'(BPG_RST);
        clear_bitmap();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table at reset settings
        rows = '{
            '{OP_TEST,    12'd0,    1, mk(ST_OK,   0, 0, 0, 4096, 512)},
            '{OP_ALLOC,   12'd0,    1, mk(ST_OK,   0, 0, 0, 4095, 511)},
            '{OP_ALLOC,   12'd0,    1, mk(ST_USED, 1, 0, 0, 4095, 511)},
            '{OP_RELEASE, 12'd4095, 1, mk(ST_FREE, 0, 0, 0, 4095, 512)},
            '{OP_FIND,    12'd0,    1, mk(ST_OK,   1, 1, 1, 4095, 511)},
            '{OP_ALLOC,   12'd4095, 1, mk(ST_OK,   0, 0, 0, 4094, 511)},
            '{OP_FIND,    12'd4095, 1, mk(ST_OK,   1, 1, 1, 4094, 511)},
            '{OP_TEST,    12'd4095, 0, none},
            '{OP_ALLOC,   12'd1,    0, none},
            '{OP_ALLOC,   12'd2,    0, none},
            '{OP_FIND,    12'd0,    0, none},
            '{OP_RELEASE, 12'd0,    1, mk(ST_OK,   1, 0, 0, 4093, 510)},
            '{OP_RELEASE, 12'd0,    1, mk(ST_FREE, 0, 0, 0, 4093, 510)},
            '{OP_ALLOC,   12'd511,  0, none},
            '{OP_ALLOC,   12'd512,  0, none},
            '{OP_FIND,    12'd2048, 0, none},
            '{OP_SPARE5,  12'd1,    0, none},
            '{OP_SPARE6,  12'd2730, 0, none},
            '{OP_SPARE7,  12'd1365, 0, none},
            '{OP_CLEAR,   12'd3000, 1, mk(ST_OK,   0, 0, 0, 4096, 512)},
            '{OP_FIND,    12'd4095, 1, mk(ST_OK,   0, 1, 4095, 4096, 512)}
        };
        foreach (rows[i]) begin
            issue(rows[i].op, rows[i].blk, rows[i].typed, rows[i].res);
            if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 17));
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_TOTAL, ph_total[ph]);
            write_reg(CFG_BPG, ph_bpg[ph]);
            issue(OP_CLEAR, BLK_W'($urandom_range(0, 4095)), 0, none);
            lim = (ph_total[ph] > BBA_MAX_BLOCKS) ? BBA_MAX_BLOCKS : ph_total[ph];
            for (int n = 0; n < 120; n++) begin
                if (lim > 0 && $urandom_range(0, 7) != 0)
                    blk = BLK_W'($urandom_range(0, lim - 1));
                else
                    blk = BLK_W'($urandom_range(0, 4095));
                issue(pick_op(), blk, 0, none);
                if (ph < 6 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 17));
            end
        end
        @(negedge clk);
        start = 1'b0;

        // drain
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatches++;
        end

        $display("%0d results checked over 8 register settings; %0d failed alloc/release",
                 results_seen, fails_seen);
        $display("find-free: %0d located a block, %0d found none", finds_hit, finds_miss);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
